// ===== rtl/date_add_days_assert.svh =====
// Assertion macros for the date adder RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef DATE_ADD_DAYS_ASSERT_SVH
`define DATE_ADD_DAYS_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define DAD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("date_add_days: same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define DAD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("date_add_days: next-cycle check failed");

`endif

// ===== rtl/dad_pkg.sv =====
// Package for the date adder: widths, calendar constants, types and helpers.
// Depends on nothing; used by every other file of the block but the assertion header.
package dad_pkg;

    localparam int DAY_W   = 5;
    localparam int MONTH_W = 4;
    localparam int YEAR_W  = 16;
    localparam int ADD_W   = 16;
    // Day plus count needs one bit more than the wider operand.
    localparam int SUM_W   = ADD_W + 1;
    // Remainder of the year by 400 stays below 512.
    localparam int REM_W   = 9;

    // The year splits as 16 * high part + low nibble, and 400 = 25 * 16.
    localparam int LOW_W       = 4;
    localparam int HI_W        = YEAR_W - LOW_W;
    localparam int PROD_W      = 2 * HI_W;
    // Quotient by 25 as (x * 2622) >> 16, exact for any 12-bit x.
    localparam int RECIP_SHIFT = 16;
    localparam logic [HI_W-1:0] RECIP_25 = 12'd2622;
    localparam logic [HI_W-1:0] MOD_25   = 12'd25;

    localparam logic [REM_W-1:0] CENTURY_1  = 9'd100;
    localparam logic [REM_W-1:0] CENTURY_2  = 9'd200;
    localparam logic [REM_W-1:0] CENTURY_3  = 9'd300;
    localparam logic [REM_W-1:0] LEAP_LAST  = 9'd399;

    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_APR = 4'd4;
    localparam logic [MONTH_W-1:0] MONTH_JUN = 4'd6;
    localparam logic [MONTH_W-1:0] MONTH_SEP = 4'd9;
    localparam logic [MONTH_W-1:0] MONTH_NOV = 4'd11;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

    localparam logic [DAY_W-1:0] LEN_LEAP_FEB = 5'd29;
    localparam logic [DAY_W-1:0] LEN_FEB      = 5'd28;
    localparam logic [DAY_W-1:0] LEN_SHORT    = 5'd30;
    localparam logic [DAY_W-1:0] LEN_LONG     = 5'd31;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MODY,
        ST_WALK,
        ST_EMIT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic mod_step;
        logic walk_step;
        logic load_out;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic day_fits;
    } t_status;

    // Length of a month; unknown month codes count as 31-day months.
    function automatic logic [DAY_W-1:0] month_length(input logic [MONTH_W-1:0] month,
                                                      input logic leap);
        logic [DAY_W-1:0] len;
        case (month)
            MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = LEN_SHORT;
            MONTH_FEB: len = leap ? LEN_LEAP_FEB : LEN_FEB;
            default:   len = LEN_LONG;
        endcase
        return len;
    endfunction

endpackage

// ===== rtl/dad_if.sv =====
// Valid/ready channel interfaces for the date adder input and result.
// Depends on dad_pkg for the field widths.
interface dad_in_if import dad_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [DAY_W-1:0]   start_day;
    logic [MONTH_W-1:0] start_month;
    logic [YEAR_W-1:0]  start_year;
    logic [ADD_W-1:0]   days_to_add;

    modport source (output valid, start_day, start_month, start_year, days_to_add,
                    input ready);
    modport sink   (input valid, start_day, start_month, start_year, days_to_add,
                    output ready);
endinterface

interface dad_out_if import dad_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [DAY_W-1:0]   new_day;
    logic [MONTH_W-1:0] new_month;
    logic [YEAR_W-1:0]  new_year;
    logic               year_overflow;

    modport source (output valid, new_day, new_month, new_year, year_overflow,
                    input ready);
    modport sink   (input valid, new_day, new_month, new_year, year_overflow,
                    output ready);
endinterface

// ===== rtl/dad_dp.sv =====
// Datapath of the date adder: day sum, year remainder unit, month walk, result register.
// Depends on dad_pkg; driven by the commands of dad_ctrl.
module dad_dp import dad_pkg::*; (
    input  logic               i_clk,
    input  t_cmd               i_cmd,
    output t_status            o_status,
    input  logic [DAY_W-1:0]   i_start_day,
    input  logic [MONTH_W-1:0] i_start_month,
    input  logic [YEAR_W-1:0]  i_start_year,
    input  logic [ADD_W-1:0]   i_days_to_add,
    output logic [DAY_W-1:0]   o_new_day,
    output logic [MONTH_W-1:0] o_new_month,
    output logic [YEAR_W-1:0]  o_new_year,
    output logic               o_year_overflow
);

    logic [SUM_W-1:0]   r_day;
    logic [MONTH_W-1:0] r_month;
    logic [YEAR_W-1:0]  r_year;
    logic [REM_W-1:0]   r_rem;
    logic               r_ovf;
    logic [DAY_W-1:0]   r_out_day;
    logic [MONTH_W-1:0] r_out_month;
    logic [YEAR_W-1:0]  r_out_year;
    logic               r_out_ovf;

    logic [HI_W-1:0]    yr_hi;
    logic [PROD_W-1:0]  q_prod;
    logic [HI_W-1:0]    q_25;
    logic [HI_W-1:0]    rem_25;
    logic [REM_W-1:0]   n_rem;
    logic               leap;
    logic [DAY_W-1:0]   len;
    logic               day_fits;

    // Year mod 400 is 16 * (high part mod 25) plus the low nibble; the quotient
    // by 25 comes from a reciprocal multiplication.
    always_comb begin
        yr_hi  = r_year[YEAR_W-1:LOW_W];
        q_prod = {{HI_W{1'b0}}, yr_hi} * {{HI_W{1'b0}}, RECIP_25};
        q_25   = HI_W'(q_prod >> RECIP_SHIFT);
        rem_25 = yr_hi - HI_W'(q_25 * MOD_25);
        n_rem  = {rem_25[REM_W-LOW_W-1:0], r_year[LOW_W-1:0]};
    end

    // Leap test from the tracked remainder and the low year bits.
    always_comb begin
        leap = (r_rem == '0) ||
               ((r_year[1:0] == 2'b00) && (r_rem != CENTURY_1) &&
                (r_rem != CENTURY_2) && (r_rem != CENTURY_3));
        len      = month_length(r_month, leap);
        day_fits = (r_day <= {{(SUM_W-DAY_W){1'b0}}, len});
    end

    assign o_status.day_fits = day_fits;

    // Working registers: load, remainder and one month crossed per walk step.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_day   <= {{(SUM_W-DAY_W){1'b0}}, i_start_day} + {1'b0, i_days_to_add};
            r_month <= i_start_month;
            r_year  <= i_start_year;
            r_rem   <= '0;
            r_ovf   <= 1'b0;
        end else if (i_cmd.mod_step) begin
            r_rem   <= n_rem;
        end else if (i_cmd.walk_step && !day_fits) begin
            r_day <= r_day - {{(SUM_W-DAY_W){1'b0}}, len};
            if (r_month >= MONTH_DEC) begin
                r_month <= MONTH_JAN;
                if (r_year == '1) begin
                    r_year <= '0;
                    r_rem  <= '0;
                    r_ovf  <= 1'b1;
                end else begin
                    r_year <= r_year + 1'b1;
                    r_rem  <= (r_rem == LEAP_LAST) ? '0 : r_rem + 1'b1;
                end
            end else begin
                r_month <= r_month + 1'b1;
            end
        end
    end

    // Result register, parts the walk from the output handshake.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_day   <= r_day[DAY_W-1:0];
            r_out_month <= r_month;
            r_out_year  <= r_year;
            r_out_ovf   <= r_ovf;
        end
    end

    assign o_new_day       = r_out_day;
    assign o_new_month     = r_out_month;
    assign o_new_year      = r_out_year;
    assign o_year_overflow = r_out_ovf;

endmodule

// ===== rtl/dad_ctrl.sv =====
// Controller of the date adder: sequences load, remainder, month walk and result.
// Depends on dad_pkg and the assertion macros in date_add_days_assert.svh.
`include "date_add_days_assert.svh"

module dad_ctrl import dad_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_cmd    o_cmd,
    input  t_status i_status
);

    t_state           r_state;
    t_state           n_state;
    logic             r_out_valid;
    logic             n_out_valid;
    logic             out_free;

    assign out_free = !r_out_valid || i_out_ready;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (i_in_valid) n_state = ST_MODY;
            ST_MODY: n_state = ST_WALK;
            ST_WALK: if (i_status.day_fits) n_state = ST_EMIT;
            ST_EMIT: if (out_free) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // Commands and handshake outputs.
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            ST_MODY: o_cmd.mod_step  = 1'b1;
            ST_WALK: o_cmd.walk_step = 1'b1;
            ST_EMIT: o_cmd.load_out  = out_free;
            default: o_cmd = '0;
        endcase
    end

    // Result valid flag.
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    // A transfer in starts the remainder step.
    `DAD_ASSERT_NXT(a_accept_starts, i_clk, i_rst_n, (o_in_ready && i_in_valid), (r_state == ST_MODY))
    // The result register is never overwritten while its transfer is pending.
    `DAD_ASSERT_IMP(a_no_overwrite, i_clk, i_rst_n, o_cmd.load_out, (!r_out_valid || i_out_ready))
    // The walk starts in the cycle after the remainder step.
    `DAD_ASSERT_NXT(a_mod_ends, i_clk, i_rst_n, (r_state == ST_MODY), (r_state == ST_WALK))
    // A fitting day ends the walk.
    `DAD_ASSERT_NXT(a_walk_ends, i_clk, i_rst_n, ((r_state == ST_WALK) && i_status.day_fits), (r_state == ST_EMIT))

endmodule

// ===== rtl/date_add_days.sv =====
// After an input transfer the block runs the year mod 400 step, then the month walk,
// one step per month crossed plus a final step, then the result load, which waits
// while the previous result is still pending. The next item is taken after the load.
// A finished result waits in its own register while the next item is taken.
// Reset (synchronous, active low) clears the controller and the result valid flag.
module date_add_days import dad_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    dad_in_if.sink    i_in,
    dad_out_if.source o_out
);

    t_cmd    cmd;
    t_status status;

    dad_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_cmd       (cmd),
        .i_status    (status)
    );

    dad_dp u_dp (
        .i_clk           (i_clk),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_start_day     (i_in.start_day),
        .i_start_month   (i_in.start_month),
        .i_start_year    (i_in.start_year),
        .i_days_to_add   (i_in.days_to_add),
        .o_new_day       (o_out.new_day),
        .o_new_month     (o_out.new_month),
        .o_new_year      (o_out.new_year),
        .o_year_overflow (o_out.year_overflow)
    );

endmodule

// ===== bench/date_add_days_tb_pkg.sv =====
// Testbench package for the date adder: request and result types, the calendar
// predictor and the class that pairs each accepted result with its expected date.
// Depends on dad_pkg for the field widths.
package date_add_days_tb_pkg;
    import dad_pkg::*;

    typedef struct packed {
        logic [DAY_W-1:0]   start_day;
        logic [MONTH_W-1:0] start_month;
        logic [YEAR_W-1:0]  start_year;
        logic [ADD_W-1:0]   days_to_add;
    } t_date_req;

    typedef struct packed {
        logic [DAY_W-1:0]   new_day;
        logic [MONTH_W-1:0] new_month;
        logic [YEAR_W-1:0]  new_year;
        logic               year_overflow;
    } t_date_res;

    // Gregorian leap rule: every 400th year, or every 4th that is not a century.
    function automatic bit is_leap(int unsigned y);
        return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
    endfunction

    // Days in a month; any code other than the 30-day months and February has 31.
    function automatic int unsigned days_in_month(int unsigned m, int unsigned y);
        case (m)
            4, 6, 9, 11: return 30;
            2:           return is_leap(y) ? 29 : 28;
            default:     return 31;
        endcase
    endfunction

    class date_add_checker;
        t_date_res   expected_dates[$];
        int unsigned mismatches;
        int unsigned results_seen;

        function new();
            mismatches   = 0;
            results_seen = 0;
        endfunction

        // Walk the summed day count forward one month at a time.
        function t_date_res advance_date(t_date_req r);
            int unsigned day;
            int unsigned month;
            int unsigned year;
            int unsigned len;
            bit          ovf;
            t_date_res   res;
            day   = r.start_day + r.days_to_add;
            month = r.start_month;
            year  = r.start_year;
            ovf   = 1'b0;
            len   = days_in_month(month, year);
            while (day > len) begin
                day   = day - len;
                month = month + 1;
                if (month > 12) begin
                    month = 1;
                    if (year == 65535) begin
                        year = 0;
                        ovf  = 1'b1;
                    end else begin
                        year = year + 1;
                    end
                end
                len = days_in_month(month, year);
            end
            res.new_day       = DAY_W'(day);
            res.new_month     = MONTH_W'(month);
            res.new_year      = YEAR_W'(year);
            res.year_overflow = ovf;
            return res;
        endfunction

        function void note_request(t_date_req r);
            expected_dates.push_back(advance_date(r));
        endfunction

        function int unsigned pending();
            return expected_dates.size();
        endfunction

        task report(string msg);
            $display("MISMATCH: %s", msg);
            mismatches++;
        endtask

        // Compare one result transfer with the oldest expected date.
        task check_result(t_date_res got);
            t_date_res want;
            if (expected_dates.size() == 0) begin
                report($sformatf("result %0d arrived with nothing expected", results_seen));
            end else begin
                want = expected_dates.pop_front();
                if (got.new_day !== want.new_day)
                    report($sformatf("result %0d new_day expected %0d got %0d",
                                     results_seen, want.new_day, got.new_day));
                if (got.new_month !== want.new_month)
                    report($sformatf("result %0d new_month expected %0d got %0d",
                                     results_seen, want.new_month, got.new_month));
                if (got.new_year !== want.new_year)
                    report($sformatf("result %0d new_year expected %0d got %0d",
                                     results_seen, want.new_year, got.new_year));
                if (got.year_overflow !== want.year_overflow)
                    report($sformatf("result %0d year_overflow expected %0d got %0d",
                                     results_seen, want.year_overflow, got.year_overflow));
            end
            results_seen++;
        endtask
    endclass

endpackage

// ===== bench/date_add_days_tb.sv =====
// Top of the date adder testbench: clock, reset, request driver, result sink,
// transfer monitor with watchdog, and the directed and random stimulus.
// Depends on dad_pkg, the dad_in_if/dad_out_if interfaces and date_add_days_tb_pkg.
module date_add_days_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import dad_pkg::*;
    import date_add_days_tb_pkg::*;

    localparam int unsigned STALL_LIMIT  = 20000;
    localparam int unsigned LONG_HOLD    = 300;
    localparam int unsigned TAIL_CYCLES  = 200;
    localparam int unsigned HOLD_ITEMS   = 10;
    localparam int unsigned RANDOM_ITEMS = 237;
    localparam int unsigned QUIET_ITEMS  = 40;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    bit tx_idle_on   = 1'b1;
    bit rx_idle_on   = 1'b1;
    bit hold_request = 1'b0;

    int unsigned     stall_cycles = 0;
    date_add_checker date_chk;

    dad_in_if  in_ch ();
    dad_out_if out_ch ();

    date_add_days dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // Free-running clock, 12 ns period.
    always #6 i_clk = ~i_clk;

    // Monitor: every transfer on either side goes to the checker; a long
    // stretch with no transfer at all ends the run.
    always @(posedge i_clk) begin : monitor
        bit moved;
        moved = 1'b0;
        if (i_rst_n) begin
            if (in_ch.valid && in_ch.ready) begin
                date_chk.note_request(t_date_req'{in_ch.start_day, in_ch.start_month,
                                                  in_ch.start_year, in_ch.days_to_add});
                moved = 1'b1;
            end
            if (out_ch.valid && out_ch.ready) begin
                date_chk.check_result(t_date_res'{out_ch.new_day, out_ch.new_month,
                                                  out_ch.new_year, out_ch.year_overflow});
                moved = 1'b1;
            end
            stall_cycles = moved ? 0 : stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("date_add_days_tb: errors");
                $finish;
            end
        end
    end

    // Result sink: random ready bursts, plus one long hold-off on request.
    initial begin : result_sink
        int unsigned hold_left;
        int unsigned gap_left;
        hold_left = 0;
        gap_left  = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else if (gap_left > 0) begin
                gap_left--;
                out_ch.ready <= 1'b0;
            end else if (rx_idle_on && $urandom_range(0, 4) == 0) begin
                gap_left = $urandom_range(0, 2);
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    function automatic t_date_req make_req(int unsigned d, int unsigned m,
                                           int unsigned y, int unsigned a);
        t_date_req r;
        r.start_day   = DAY_W'(d);
        r.start_month = MONTH_W'(m);
        r.start_year  = YEAR_W'(y);
        r.days_to_add = ADD_W'(a);
        return r;
    endfunction

    // Mostly real dates with short counts; some full-range counts and some
    // out-of-range day and month codes.
    function automatic t_date_req random_request();
        t_date_req   r;
        int unsigned m;
        case ($urandom_range(0, 3))
            0:       r.start_year = YEAR_W'(65535 - $urandom_range(0, 40));
            1:       r.start_year = YEAR_W'($urandom_range(0, 163) * 400
                                            + $urandom_range(0, 3) * 100
                                            + $urandom_range(0, 2) - 1);
            default: r.start_year = YEAR_W'($urandom);
        endcase
        if ($urandom_range(0, 99) < 80) begin
            m = $urandom_range(1, 12);
            r.start_month = MONTH_W'(m);
            r.start_day   = DAY_W'($urandom_range(1, days_in_month(m, r.start_year)));
        end else begin
            r.start_month = MONTH_W'($urandom);
            r.start_day   = DAY_W'($urandom);
        end
        case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10: r.days_to_add = ADD_W'($urandom_range(0, 60));
            11, 12, 13, 14, 15:               r.days_to_add = ADD_W'($urandom_range(0, 1500));
            16, 17:                           r.days_to_add = ADD_W'($urandom);
            18:                               r.days_to_add = '1;
            default:                          r.days_to_add = ADD_W'($urandom_range(365, 366));
        endcase
        return r;
    endfunction

    // Offer one request and hold it until the transfer happens.
    task automatic send_request(input t_date_req r);
        if (tx_idle_on && $urandom_range(0, 3) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.start_day   <= r.start_day;
        in_ch.start_month <= r.start_month;
        in_ch.start_year  <= r.start_year;
        in_ch.days_to_add <= r.days_to_add;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
    endtask

    // Stop offering and wait until every expected date has come back.
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (date_chk.pending() != 0) @(posedge i_clk);
    endtask

    initial begin : stimulus
        t_date_req r;
        date_chk = new();
        in_ch.valid       <= 1'b0;
        in_ch.start_day   <= '0;
        in_ch.start_month <= '0;
        in_ch.start_year  <= '0;
        in_ch.days_to_add <= '0;
        i_rst_n           <= 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: calendar corners, leap rules, odd codes and field extremes.
        send_request(make_req(1, 1, 2024, 0));
        send_request(make_req(0, 5, 2023, 0));        // day zero passes through
        send_request(make_req(0, 3, 2023, 5));
        send_request(make_req(31, 2, 2023, 0));       // day past the end of February
        send_request(make_req(30, 2, 2024, 0));
        send_request(make_req(28, 2, 2024, 1));
        send_request(make_req(28, 2, 1900, 1));       // century, not leap
        send_request(make_req(28, 2, 2000, 1));       // 400th year, leap
        send_request(make_req(31, 12, 65535, 1));     // year wraps to zero
        send_request(make_req(31, 12, 2023, 1));
        send_request(make_req(15, 0, 100, 20));       // month zero is crossed
        send_request(make_req(10, 0, 5, 0));
        send_request(make_req(31, 13, 7, 0));         // month above twelve, day fits
        send_request(make_req(31, 15, 65535, 1));     // month above twelve, crossed with wrap
        send_request(make_req(20, 14, 300, 15));
        send_request(make_req(31, 1, 0, 65535));
        send_request(make_req(31, 15, 65535, 65535));
        send_request(make_req(1, 12, 65535, 65535));
        send_request(make_req(0, 0, 0, 0));
        send_request(make_req(30, 4, 2100, 1));
        send_request(make_req(31, 11, 399, 1));
        send_request(make_req(29, 2, 400, 365));
        send_request(make_req(31, 8, 65535, 153));

        // Long hold-off on the result side while requests keep coming.
        hold_request = 1'b1;
        repeat (HOLD_ITEMS) begin
            r = random_request();
            r.days_to_add = ADD_W'($urandom_range(0, 40));
            send_request(r);
        end
        wait_drained();

        // Random part; the last stretch runs with no idling on either side.
        for (int unsigned i = 0; i < RANDOM_ITEMS; i++) begin
            if (i == RANDOM_ITEMS - QUIET_ITEMS) begin
                tx_idle_on = 1'b0;
                rx_idle_on = 1'b0;
            end
            send_request(random_request());
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (date_chk.mismatches == 0 && date_chk.pending() == 0) begin
            $display("date_add_days_tb: clean");
        end else begin
            $display("date_add_days_tb: errors");
        end
        $finish;
    end

endmodule
